### rtl/ncct_pkg.sv
// ncct_pkg: shared types, constants and width helpers for the ncc template matcher
// used by ncct_ctrl, ncct_dp and ncc_template_match_top; no dependencies
package ncct_pkg;

  localparam int MaxTemplateSideDef  = 32;
  localparam int MaxImageWidthDef    = 1024;
  localparam int ScoreFractionBitsDef = 14;
  localparam int RowLimit            = 1024;

  localparam logic [5:0]  TwReset = 6'd8;
  localparam logic [5:0]  ThReset = 6'd8;
  localparam logic [10:0] IwReset = 11'd640;
  localparam logic [10:0] IhReset = 11'd480;

  localparam logic [1:0] CfgTemplateWidth  = 2'd0;
  localparam logic [1:0] CfgTemplateHeight = 2'd1;
  localparam logic [1:0] CfgImageWidth     = 2'd2;
  localparam logic [1:0] CfgImageHeight    = 2'd3;

  localparam logic ActTemplate = 1'b0;
  localparam logic ActSource   = 1'b1;

  typedef enum logic [3:0] {
    DP_HOLD,
    DP_MUL,
    DP_SUB,
    DP_PROD_LD,
    DP_PROD,
    DP_ROOT_LD,
    DP_ROOT,
    DP_DIV_LD,
    DP_DIV,
    DP_FIN
  } dp_op_e;

  typedef struct packed {
    logic   tmpl_we;
    logic   line_we;
    logic   rd_en;
    logic   acc_clr;
    dp_op_e op;
    logic   out_load;
    logic   out_err;
    logic   out_frame;
    logic   best_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_den;
    logic it_done;
    logic out_free;
  } dp_status_t;

  function automatic int ncct_nw(int mt);
    return $clog2(mt * mt + 1);
  endfunction

  function automatic int ncct_taw(int mt);
    return (mt > 1) ? $clog2(mt * mt) : 1;
  endfunction

  function automatic int ncct_rw(int mt);
    return (mt > 1) ? $clog2(mt) : 1;
  endfunction

  function automatic int ncct_cw(int mw);
    return $clog2(mw);
  endfunction

  function automatic int ncct_law(int mt, int mw);
    return $clog2(mt * (2 ** $clog2(mw)));
  endfunction

endpackage

### rtl/ncct_ram.sv
// ncct_ram: generic single write port, single read port ram with registered read
// no dependencies
module ncct_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/ncct_dp.sv
// ncct_dp: template and line memories, window sums, serial product, root and divide,
// best tracking and output register; depends on ncct_pkg and ncct_ram
module ncct_dp #(
  parameter int MaxT = 32,
  parameter int MaxW = 1024,
  parameter int Frac = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ncct_pkg::dp_cmd_t                    cmd_i,
  output ncct_pkg::dp_status_t                 status_o,
  input  logic [7:0]                           pixel_i,
  input  logic [ncct_pkg::ncct_nw(MaxT)-1:0]   n_i,
  input  logic [ncct_pkg::ncct_taw(MaxT)-1:0]  tmpl_waddr_i,
  input  logic [ncct_pkg::ncct_taw(MaxT)-1:0]  tmpl_raddr_i,
  input  logic [ncct_pkg::ncct_law(MaxT, MaxW)-1:0] line_waddr_i,
  input  logic [ncct_pkg::ncct_law(MaxT, MaxW)-1:0] line_raddr_i,
  input  logic [9:0]                           win_x_i,
  input  logic [9:0]                           win_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [15:0]                          score_o,
  output logic [9:0]                           wx_o,
  output logic [9:0]                           wy_o,
  output logic [9:0]                           bx_o,
  output logic [9:0]                           by_o,
  output logic [14:0]                          bs_o,
  output logic                                 frame_o,
  output logic                                 err_o
);
  import ncct_pkg::*;

  localparam int NW  = ncct_nw(MaxT);
  localparam int TAW = ncct_taw(MaxT);
  localparam int LAW = ncct_law(MaxT, MaxW);
  localparam int SW  = NW + 8;
  localparam int QW  = NW + 16;
  localparam int PW  = 2 * NW + 16;
  localparam int DW  = 2 * PW;
  localparam int BW  = PW + Frac + 2;
  localparam int KW  = $clog2(BW);
  localparam int SCW = Frac + 2;

  logic [7:0] x_rd, t_rd;
  logic [15:0] xx, xt, tt;
  logic rd_v_q;
  logic [SW-1:0] sx_q, st_q;
  logic [QW-1:0] sxx_q, sxy_q, stt_q;
  logic [PW-1:0] p_nsxy_q, p_sxst_q, p_nsxx_q, p_sxsx_q, p_nstt_q, p_stst_q;
  logic [PW:0] num;
  logic neg_q;
  logic [PW-1:0] mag_q, varx_q, vart_q;
  logic [DW-1:0] acc_q, mcand_q, dsh_q;
  logic [PW-1:0] mpl_q, root_q;
  logic [PW+1:0] rem_q, rt, trial, rt2;
  logic ge, ge2;
  logic [BW-1:0] dvd_q;
  logic [PW:0] drem_q, den_q;
  logic [KW-1:0] cnt_q;
  logic [Frac:0] best_q, qc;
  logic [9:0] bx_q, by_q;
  logic signed [SCW-1:0] sc_q;
  logic signed [31:0] sc_ext;
  logic [31:0] bs_ext;
  logic zero_den;

  ncct_ram #(.Width(8), .Depth(MaxT * MaxT)) u_tmpl_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tmpl_we),
    .waddr_i (tmpl_waddr_i),
    .wdata_i (pixel_i),
    .raddr_i (tmpl_raddr_i),
    .rdata_o (t_rd)
  );

  ncct_ram #(.Width(8), .Depth(MaxT * (2 ** ncct_cw(MaxW)))) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line_we),
    .waddr_i (line_waddr_i),
    .wdata_i (pixel_i),
    .raddr_i (line_raddr_i),
    .rdata_o (x_rd)
  );

  assign xx = {8'd0, x_rd} * {8'd0, x_rd};
  assign xt = {8'd0, x_rd} * {8'd0, t_rd};
  assign tt = {8'd0, t_rd} * {8'd0, t_rd};
  assign num = {1'b0, p_nsxy_q} - {1'b0, p_sxst_q};
  assign zero_den = (varx_q == '0) || (vart_q == '0);

  assign rt    = {rem_q[PW-1:0], dsh_q[DW-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign ge    = rt >= trial;
  assign rt2   = {drem_q, dvd_q[BW-1]};
  assign ge2   = rt2 >= {1'b0, den_q};

  always_comb begin
    if (dvd_q > (BW'(1) << Frac)) begin
      qc = (Frac + 1)'(1) << Frac;
    end else begin
      qc = dvd_q[Frac:0];
    end
  end

  assign sc_ext = 32'(sc_q);
  assign bs_ext = 32'(best_q);

  // window sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      sx_q  <= '0;
      st_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
      stt_q <= '0;
    end else if (rd_v_q) begin
      sx_q  <= sx_q + SW'(x_rd);
      st_q  <= st_q + SW'(t_rd);
      sxx_q <= sxx_q + QW'(xx);
      sxy_q <= sxy_q + QW'(xt);
      stt_q <= stt_q + QW'(tt);
    end
  end

  // score arithmetic
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_HOLD: begin
      end
      DP_MUL: begin
        p_nsxy_q <= PW'(n_i) * PW'(sxy_q);
        p_sxst_q <= PW'(sx_q) * PW'(st_q);
        p_nsxx_q <= PW'(n_i) * PW'(sxx_q);
        p_sxsx_q <= PW'(sx_q) * PW'(sx_q);
        p_nstt_q <= PW'(n_i) * PW'(stt_q);
        p_stst_q <= PW'(st_q) * PW'(st_q);
      end
      DP_SUB: begin
        neg_q  <= num[PW];
        mag_q  <= num[PW] ? PW'(-num) : num[PW-1:0];
        varx_q <= p_nsxx_q - p_sxsx_q;
        vart_q <= p_nstt_q - p_stst_q;
      end
      DP_PROD_LD: begin
        acc_q   <= '0;
        mcand_q <= DW'(vart_q);
        mpl_q   <= varx_q;
        cnt_q   <= KW'(PW - 1);
      end
      DP_PROD: begin
        if (mpl_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        mcand_q <= {mcand_q[DW-2:0], 1'b0};
        mpl_q   <= {1'b0, mpl_q[PW-1:1]};
        cnt_q   <= cnt_q - KW'(1);
      end
      DP_ROOT_LD: begin
        dsh_q  <= acc_q;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= KW'(PW - 1);
      end
      DP_ROOT: begin
        rem_q  <= ge ? rt - trial : rt;
        root_q <= {root_q[PW-2:0], ge};
        dsh_q  <= {dsh_q[DW-3:0], 2'b00};
        cnt_q  <= cnt_q - KW'(1);
      end
      DP_DIV_LD: begin
        dvd_q  <= (BW'(mag_q) << (Frac + 1)) + BW'(root_q);
        den_q  <= {root_q, 1'b0};
        drem_q <= '0;
        cnt_q  <= KW'(BW - 1);
      end
      DP_DIV: begin
        drem_q <= ge2 ? (PW + 1)'(rt2 - {1'b0, den_q}) : (PW + 1)'(rt2);
        dvd_q  <= {dvd_q[BW-2:0], ge2};
        cnt_q  <= cnt_q - KW'(1);
      end
      DP_FIN: begin
        if (zero_den) begin
          sc_q <= '0;
        end else if (neg_q) begin
          sc_q <= -SCW'(qc);
        end else begin
          sc_q <= SCW'(qc);
        end
      end
      default: begin
      end
    endcase
  end

  // best match and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      bx_q        <= '0;
      by_q        <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.op == DP_FIN && !zero_den && !neg_q && qc > best_q) begin
        best_q <= qc;
        bx_q   <= win_x_i;
        by_q   <= win_y_i;
      end
      if (cmd_i.best_clr || (cmd_i.out_load && cmd_i.out_frame)) begin
        best_q <= '0;
        bx_q   <= '0;
        by_q   <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      frame_o <= cmd_i.out_frame;
      err_o   <= cmd_i.out_err;
      if (cmd_i.out_err) begin
        score_o <= '0;
        wx_o    <= '0;
        wy_o    <= '0;
        bx_o    <= '0;
        by_o    <= '0;
        bs_o    <= '0;
      end else begin
        score_o <= sc_ext[15:0];
        wx_o    <= win_x_i;
        wy_o    <= win_y_i;
        bx_o    <= bx_q;
        by_o    <= by_q;
        bs_o    <= bs_ext[14:0];
      end
    end
  end

  assign status_o.zero_den = zero_den;
  assign status_o.it_done  = (cnt_q == '0);
  assign status_o.out_free = !out_valid_o || out_ready_i;

endmodule

### rtl/ncct_ctrl.sv
// ncct_ctrl: configuration registers, raster counters and the sequencing state machine
// depends on ncct_pkg
module ncct_ctrl #(
  parameter int MaxT = 32,
  parameter int MaxW = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_addr_i,
  input  logic [10:0]                          cfg_data_i,
  input  logic                                 s_valid_i,
  output logic                                 s_ready_o,
  input  logic                                 s_action_i,
  input  ncct_pkg::dp_status_t                 status_i,
  output ncct_pkg::dp_cmd_t                    cmd_o,
  output logic [ncct_pkg::ncct_nw(MaxT)-1:0]   n_o,
  output logic [ncct_pkg::ncct_taw(MaxT)-1:0]  tmpl_waddr_o,
  output logic [ncct_pkg::ncct_taw(MaxT)-1:0]  tmpl_raddr_o,
  output logic [ncct_pkg::ncct_law(MaxT, MaxW)-1:0] line_waddr_o,
  output logic [ncct_pkg::ncct_law(MaxT, MaxW)-1:0] line_raddr_o,
  output logic [9:0]                           win_x_o,
  output logic [9:0]                           win_y_o
);
  import ncct_pkg::*;

  localparam int NW  = ncct_nw(MaxT);
  localparam int TAW = ncct_taw(MaxT);
  localparam int RW  = ncct_rw(MaxT);
  localparam int CW  = ncct_cw(MaxW);
  localparam int LAW = ncct_law(MaxT, MaxW);
  localparam int TSW = $clog2(MaxT + 1);
  localparam int TCX = (TSW > 6) ? TSW : 6;
  localparam int IWX = ($clog2(MaxW + 1) > 11) ? $clog2(MaxW + 1) : 11;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_ACC   = 13'b0000000000010,
    S_DRAIN = 13'b0000000000100,
    S_MUL   = 13'b0000000001000,
    S_SUB   = 13'b0000000010000,
    S_CHK   = 13'b0000000100000,
    S_PROD  = 13'b0000001000000,
    S_RLD   = 13'b0000010000000,
    S_ROOT  = 13'b0000100000000,
    S_DLD   = 13'b0001000000000,
    S_DIV   = 13'b0010000000000,
    S_FIN   = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] tw_q, th_q;
  logic [10:0] iw_q, ih_q;
  logic [TSW-1:0] tw_c, th_c;
  logic [IWX-1:0] iw_c;
  logic [10:0] ih_c;
  logic [CW-1:0] col_q, col_d, wx_q, wx_d;
  logic [9:0] row_q, row_d, wy_q, wy_d;
  logic [RW-1:0] ring_q, ring_d, rring_q, rring_d, ring_nx, top_ring, th1;
  logic [TAW-1:0] tidx_q, tidx_d, tcur, tnext, lin_q, lin_d;
  logic [TSW-1:0] ar_q, ar_d, ac_q, ac_d;
  logic frame_q, frame_d, err_q, err_d;
  logic last_col, frame_end, size_err, win;
  logic [CW-1:0] rcol;
  logic [RW:0] ring_wrap;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q <= TwReset;
      th_q <= ThReset;
      iw_q <= IwReset;
      ih_q <= IhReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CfgTemplateWidth:  tw_q <= cfg_data_i[5:0];
        CfgTemplateHeight: th_q <= cfg_data_i[5:0];
        CfgImageWidth:     iw_q <= cfg_data_i;
        CfgImageHeight:    ih_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    priority if (tw_q == '0) begin
      tw_c = TSW'(1);
    end else if (TCX'(tw_q) > TCX'(MaxT)) begin
      tw_c = TSW'(MaxT);
    end else begin
      tw_c = TSW'(tw_q);
    end
    priority if (th_q == '0) begin
      th_c = TSW'(1);
    end else if (TCX'(th_q) > TCX'(MaxT)) begin
      th_c = TSW'(MaxT);
    end else begin
      th_c = TSW'(th_q);
    end
    priority if (iw_q == '0) begin
      iw_c = IWX'(1);
    end else if (IWX'(iw_q) > IWX'(MaxW)) begin
      iw_c = IWX'(MaxW);
    end else begin
      iw_c = IWX'(iw_q);
    end
    priority if (ih_q == '0) begin
      ih_c = 11'd1;
    end else if (ih_q > 11'(RowLimit)) begin
      ih_c = 11'(RowLimit);
    end else begin
      ih_c = ih_q;
    end
  end

  assign n_o = NW'(tw_c * th_c);

  // raster position and window geometry
  assign last_col  = IWX'(col_q) + IWX'(1) >= iw_c;
  assign frame_end = last_col && (11'(row_q) + 11'd1 >= ih_c);
  assign size_err  = (IWX'(tw_c) > iw_c) || (11'(th_c) > ih_c);
  assign win       = (IWX'(col_q) + IWX'(1) >= IWX'(tw_c)) && (11'(row_q) + 11'd1 >= 11'(th_c));
  assign ring_nx   = (ring_q == RW'(MaxT - 1)) ? '0 : ring_q + RW'(1);
  assign th1       = RW'(th_c - TSW'(1));
  assign ring_wrap = (RW + 1)'(ring_q) + (RW + 1)'(MaxT) - (RW + 1)'(th1);
  assign top_ring  = (ring_q >= th1) ? ring_q - th1 : ring_wrap[RW-1:0];

  assign tcur  = (NW'(tidx_q) >= n_o) ? '0 : tidx_q;
  assign tnext = (NW'(tcur) + NW'(1) >= n_o) ? '0 : tcur + TAW'(1);

  assign rcol         = CW'(IWX'(wx_q) + IWX'(ac_q));
  assign tmpl_waddr_o = tcur;
  assign tmpl_raddr_o = lin_q;
  assign line_waddr_o = LAW'({ring_q, col_q});
  assign line_raddr_o = LAW'({rring_q, rcol});
  assign win_x_o      = 10'(wx_q);
  assign win_y_o      = wy_q;
  assign s_ready_o    = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    ring_d  = ring_q;
    rring_d = rring_q;
    tidx_d  = tidx_q;
    lin_d   = lin_q;
    ar_d    = ar_q;
    ac_d    = ac_q;
    wx_d    = wx_q;
    wy_d    = wy_q;
    frame_d = frame_q;
    err_d   = err_q;
    cmd_o   = '{op: DP_HOLD, default: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          if (s_action_i == ActTemplate) begin
            cmd_o.tmpl_we = 1'b1;
            tidx_d        = tnext;
          end else begin
            cmd_o.line_we = 1'b1;
            if (frame_end) begin
              col_d  = '0;
              row_d  = '0;
              ring_d = '0;
            end else if (last_col) begin
              col_d  = '0;
              row_d  = row_q + 10'd1;
              ring_d = ring_nx;
            end else begin
              col_d = col_q + CW'(1);
            end
            wx_d    = CW'(IWX'(col_q) + IWX'(1) - IWX'(tw_c));
            wy_d    = 10'(11'(row_q) + 11'd1 - 11'(th_c));
            frame_d = frame_end;
            if (size_err) begin
              if (frame_end) begin
                err_d   = 1'b1;
                state_d = S_OUT;
              end
            end else if (win) begin
              err_d         = 1'b0;
              cmd_o.acc_clr = 1'b1;
              rring_d       = top_ring;
              lin_d         = '0;
              ar_d          = '0;
              ac_d          = '0;
              state_d       = S_ACC;
            end else if (frame_end) begin
              cmd_o.best_clr = 1'b1;
            end
          end
        end
      end
      S_ACC: begin
        cmd_o.rd_en = 1'b1;
        lin_d       = lin_q + TAW'(1);
        if (ac_q == tw_c - TSW'(1)) begin
          ac_d    = '0;
          ar_d    = ar_q + TSW'(1);
          rring_d = (rring_q == RW'(MaxT - 1)) ? '0 : rring_q + RW'(1);
          if (ar_q == th_c - TSW'(1)) begin
            state_d = S_DRAIN;
          end
        end else begin
          ac_d = ac_q + TSW'(1);
        end
      end
      S_DRAIN: state_d = S_MUL;
      S_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = S_SUB;
      end
      S_SUB: begin
        cmd_o.op = DP_SUB;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (status_i.zero_den) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = DP_PROD_LD;
          state_d  = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.op = DP_PROD;
        if (status_i.it_done) state_d = S_RLD;
      end
      S_RLD: begin
        cmd_o.op = DP_ROOT_LD;
        state_d  = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.op = DP_ROOT;
        if (status_i.it_done) state_d = S_DLD;
      end
      S_DLD: begin
        cmd_o.op = DP_DIV_LD;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = DP_DIV;
        if (status_i.it_done) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = DP_FIN;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_err   = err_q;
          cmd_o.out_frame = frame_q;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      ring_q  <= '0;
      tidx_q  <= '0;
      rring_q <= '0;
      lin_q   <= '0;
      ar_q    <= '0;
      ac_q    <= '0;
      frame_q <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      ring_q  <= ring_d;
      tidx_q  <= tidx_d;
      rring_q <= rring_d;
      lin_q   <= lin_d;
      ar_q    <= ar_d;
      ac_q    <= ac_d;
      frame_q <= frame_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wx_q <= wx_d;
    wy_q <= wy_d;
  end

`ifndef SYNTH
  a_acc_tmpl_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (NW'(lin_q) < n_o))
    else $error("template read beyond template size");

  a_acc_row_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (ar_q < th_c))
    else $error("window row counter beyond template height");

  a_ring_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((RW + 1)'(ring_q) < (RW + 1)'(MaxT)) && ((RW + 1)'(rring_q) < (RW + 1)'(MaxT)))
    else $error("line ring index out of range");
`endif

endmodule

### rtl/ncc_template_match_top.sv
// Template matcher: a template is loaded in raster order, then source pixels stream in
// and each pixel that closes a full window gets one result with that window's normalized
// cross-correlation score in signed fixed point, the window corner and the best match of
// the frame so far; if the template does not fit the image, one size-error result ends
// the frame instead. One item is handled at a time. The window sums go through one
// template and one line memory read per cycle, and the variance product, square root and
// divide run one bit per cycle in serial units that share one iteration counter; a window
// with zero variance skips those. Results wait in an output register; no memory clearing
// at reset.
// depends on ncct_pkg, ncct_ctrl, ncct_dp, ncct_ram
module ncc_template_match_top #(
  parameter int MAX_TEMPLATE_SIDE   = ncct_pkg::MaxTemplateSideDef,
  parameter int MAX_IMAGE_WIDTH     = ncct_pkg::MaxImageWidthDef,
  parameter int SCORE_FRACTION_BITS = ncct_pkg::ScoreFractionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // pixel
  input  logic        s_axis_tuser_i,   // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // window_score, window_x, window_y, best_x, best_y, best_score, zero pad
  output logic [71:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // frame_done
  output logic        m_axis_tuser_o    // size_error
);
  import ncct_pkg::*;

  localparam int NW  = ncct_nw(MAX_TEMPLATE_SIDE);
  localparam int TAW = ncct_taw(MAX_TEMPLATE_SIDE);
  localparam int LAW = ncct_law(MAX_TEMPLATE_SIDE, MAX_IMAGE_WIDTH);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [NW-1:0]  n;
  logic [TAW-1:0] tmpl_waddr, tmpl_raddr;
  logic [LAW-1:0] line_waddr, line_raddr;
  logic [9:0]  win_x, win_y, wx, wy, bx, by;
  logic [15:0] score;
  logic [14:0] bs;

  ncct_ctrl #(
    .MaxT (MAX_TEMPLATE_SIDE),
    .MaxW (MAX_IMAGE_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_valid_i    (s_axis_tvalid_i),
    .s_ready_o    (s_axis_tready_o),
    .s_action_i   (s_axis_tuser_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .n_o          (n),
    .tmpl_waddr_o (tmpl_waddr),
    .tmpl_raddr_o (tmpl_raddr),
    .line_waddr_o (line_waddr),
    .line_raddr_o (line_raddr),
    .win_x_o      (win_x),
    .win_y_o      (win_y)
  );

  ncct_dp #(
    .MaxT (MAX_TEMPLATE_SIDE),
    .MaxW (MAX_IMAGE_WIDTH),
    .Frac (SCORE_FRACTION_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .pixel_i      (s_axis_tdata_i),
    .n_i          (n),
    .tmpl_waddr_i (tmpl_waddr),
    .tmpl_raddr_i (tmpl_raddr),
    .line_waddr_i (line_waddr),
    .line_raddr_i (line_raddr),
    .win_x_i      (win_x),
    .win_y_i      (win_y),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .score_o      (score),
    .wx_o         (wx),
    .wy_o         (wy),
    .bx_o         (bx),
    .by_o         (by),
    .bs_o         (bs),
    .frame_o      (m_axis_tlast_o),
    .err_o        (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {1'b0, bs, by, bx, wy, wx, score};

endmodule
